>>> sv/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helpers shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> sv/dtp_pkg.sv
// ---------------------------------------------------------------------------
// dtp_pkg
// Types and constants of the tuning programmer.
// ---------------------------------------------------------------------------
`default_nettype none
package dtp_pkg;

  localparam int FREQ_W  = 20;
  localparam int SCALE_W = 32;
  localparam int PROD_W  = FREQ_W + SCALE_W;

  localparam logic [1:0] ACT_TICK    = 2'd0;
  localparam logic [1:0] ACT_BUTTON  = 2'd1;
  localparam logic [1:0] ACT_PROGRAM = 2'd2;

  localparam logic KIND_WORD  = 1'b0;
  localparam logic KIND_LINES = 1'b1;

  localparam logic [1:0] WAVE_SQUARE   = 2'd1;
  localparam logic [1:0] WAVE_TRIANGLE = 2'd2;

  localparam logic [1:0] REG_SCALE = 2'd0;
  localparam logic [1:0] REG_WAVE  = 2'd1;
  localparam logic [1:0] REG_BYTE  = 2'd2;

  localparam logic [15:0] CTRL_WORD     = 16'h2100;
  localparam logic [15:0] PHASE_WORD    = 16'hC000;
  localparam logic [1:0]  FREQ_TAG      = 2'b01;
  localparam logic [15:0] SINE_WORD     = 16'h2000;
  localparam logic [15:0] SQUARE_WORD   = 16'h2020;
  localparam logic [15:0] TRIANGLE_WORD = 16'h2002;

  localparam logic [31:0]       SCALE_RESET = 32'd960767921;
  localparam logic [7:0]        BYTE_RESET  = 8'hA6;
  localparam logic [7:0]        MASK_RESET  = 8'h80;
  localparam logic [FREQ_W-1:0] FREQ_RESET  = 20'd2000;

  localparam logic [FREQ_W-1:0] FREQ_LIM0  = 20'd10000;
  localparam logic [FREQ_W-1:0] FREQ_LIM1  = 20'd100000;
  localparam logic [FREQ_W-1:0] FREQ_LIM2  = 20'd1000000;
  localparam logic [FREQ_W-1:0] FREQ_STEP0 = 20'd1000;
  localparam logic [FREQ_W-1:0] FREQ_STEP1 = 20'd10000;
  localparam logic [FREQ_W-1:0] FREQ_STEP2 = 20'd100000;
  localparam logic [FREQ_W-1:0] FREQ_WRAP  = 20'd1000;

  localparam logic [2:0] WORD_LAST = 3'd4;

  typedef struct packed {
    logic              kind;
    logic [FREQ_W-1:0] freq;
    logic              data_lvl;
    logic              clock_lvl;
  } stage1_t;

  typedef struct packed {
    logic        kind;
    logic [13:0] lo;
    logic [13:0] hi;
    logic [15:0] wave_word;
    logic        data_lvl;
    logic        clock_lvl;
  } stage2_t;

endpackage
`default_nettype wire

>>> sv/dds_tuning_programmer_manchester.sv
// ---------------------------------------------------------------------------
// dds_tuning_programmer_manchester
// Steps the synthesizer frequency, sends its five control words and drives
// a Manchester-coded burst line with its clock.
//
//  channel | signals                                   | direction
//  in      | in_valid in_ready action psk_pin          | sink
//  out     | out_valid out_ready result_kind ...       | source
//  cfg     | cfg_wr_en cfg_index cfg_data              | sink, write only
//
//  An item passes an input register (state updated on transfer) and a
//  result register after the tuning multiplier. A tick yields one result,
//  a button or program item five, one per cycle from the result register
//  while out is ready; a new item enters it as the last word is taken.
//  Ticks pass one per cycle unless out stalls; a stall holds the result
//  register and backpressures in. Synchronous rst resets all but s1/s2 data.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module dds_tuning_programmer_manchester #(
  parameter int TUNING_BITS = 28
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  action,
  input  wire logic        psk_pin,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             result_kind,
  output logic [15:0]      serial_word,
  output logic             last_word,
  output logic             data_level,
  output logic             clock_level,
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [31:0] tuning_scale;
  logic [1:0]  wave_select;
  logic [7:0]  burst_byte;

  logic [dtp_pkg::FREQ_W-1:0] out_frequency, out_frequency_next;
  logic       burst_active, burst_active_next;
  logic [7:0] bit_mask, bit_mask_next;
  logic [1:0] half_count, half_count_next;
  logic       data_line, data_line_next;
  logic       clock_line, clock_line_next;

  dtp_pkg::stage1_t s1, s1_next;
  logic             s1_valid, s1_valid_next;
  dtp_pkg::stage2_t s2, s2_next;
  logic             s2_valid;
  logic [2:0]       word_idx;

  logic in_xfer, out_xfer, s2_free, s1_move, item_has_result, one;
  logic [1:0] hc_inc;
  logic [7:0] mask_shift;
  logic [dtp_pkg::PROD_W-1:0] prod, ftw;
  logic [27:0] ftw_sel;

  assign out_valid = s2_valid;
  assign out_xfer  = out_valid & out_ready;
  assign s2_free   = out_xfer & last_word;
  assign s1_move   = s1_valid & (~s2_valid | s2_free);
  assign in_ready  = ~s1_valid | s1_move;
  assign in_xfer   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tuning_scale <= dtp_pkg::SCALE_RESET;
      wave_select  <= 2'd0;
      burst_byte   <= dtp_pkg::BYTE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        dtp_pkg::REG_SCALE: tuning_scale <= cfg_data;
        dtp_pkg::REG_WAVE:  wave_select  <= cfg_data[1:0];
        dtp_pkg::REG_BYTE:  burst_byte   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    out_frequency_next = out_frequency;
    burst_active_next  = burst_active;
    bit_mask_next      = bit_mask;
    half_count_next    = half_count;
    data_line_next     = data_line;
    clock_line_next    = clock_line;
    item_has_result    = 1'b0;
    one                = |(burst_byte & bit_mask);
    hc_inc             = half_count + 2'd1;
    mask_shift         = bit_mask >> 1;
    case (action)
      dtp_pkg::ACT_TICK: begin
        item_has_result = 1'b1;
        clock_line_next = ~clock_line;
        if (burst_active) begin
          if (hc_inc == 2'd1) begin
            data_line_next  = one;
            half_count_next = hc_inc;
          end else begin
            data_line_next  = ~one;
            half_count_next = 2'd0;
            bit_mask_next   = mask_shift;
          end
          if (bit_mask_next == 8'd0) begin
            bit_mask_next     = dtp_pkg::MASK_RESET;
            burst_active_next = 1'b0;
            data_line_next    = 1'b0;
          end
        end
      end
      dtp_pkg::ACT_BUTTON: begin
        item_has_result = 1'b1;
        if (out_frequency < dtp_pkg::FREQ_LIM0)
          out_frequency_next = out_frequency + dtp_pkg::FREQ_STEP0;
        else if (out_frequency < dtp_pkg::FREQ_LIM1)
          out_frequency_next = out_frequency + dtp_pkg::FREQ_STEP1;
        else if (out_frequency < dtp_pkg::FREQ_LIM2)
          out_frequency_next = out_frequency + dtp_pkg::FREQ_STEP2;
        else
          out_frequency_next = dtp_pkg::FREQ_WRAP;
        if (!psk_pin) burst_active_next = 1'b1;
      end
      dtp_pkg::ACT_PROGRAM: item_has_result = 1'b1;
      default: ;
    endcase
    s1_next.kind      = (action == dtp_pkg::ACT_TICK) ? dtp_pkg::KIND_LINES
                                                      : dtp_pkg::KIND_WORD;
    s1_next.freq      = out_frequency_next;
    s1_next.data_lvl  = data_line_next;
    s1_next.clock_lvl = clock_line_next;
  end

  always_comb begin
    s1_valid_next = s1_valid;
    if (s1_move) s1_valid_next = 1'b0;
    if (in_xfer && item_has_result) s1_valid_next = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_frequency <= dtp_pkg::FREQ_RESET;
      burst_active  <= 1'b0;
      bit_mask      <= dtp_pkg::MASK_RESET;
      half_count    <= 2'd0;
      data_line     <= 1'b0;
      clock_line    <= 1'b0;
      s1_valid      <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
      if (in_xfer) begin
        out_frequency <= out_frequency_next;
        burst_active  <= burst_active_next;
        bit_mask      <= bit_mask_next;
        half_count    <= half_count_next;
        data_line     <= data_line_next;
        clock_line    <= clock_line_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer && item_has_result) s1 <= s1_next;
  end

  // tuning word, doubled for square wave
  always_comb begin
    prod              = dtp_pkg::PROD_W'(s1.freq) * dtp_pkg::PROD_W'(tuning_scale);
    ftw               = prod >> TUNING_BITS;
    s2_next.kind      = s1.kind;
    s2_next.data_lvl  = s1.data_lvl;
    s2_next.clock_lvl = s1.clock_lvl;
    ftw_sel           = ftw[27:0];
    case (wave_select)
      dtp_pkg::WAVE_SQUARE: begin
        s2_next.wave_word = dtp_pkg::SQUARE_WORD;
        ftw_sel           = {ftw[26:0], 1'b0};
      end
      dtp_pkg::WAVE_TRIANGLE: s2_next.wave_word = dtp_pkg::TRIANGLE_WORD;
      default:                s2_next.wave_word = dtp_pkg::SINE_WORD;
    endcase
    s2_next.lo = ftw_sel[13:0];
    s2_next.hi = ftw_sel[27:14];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      word_idx <= 3'd0;
    end else if (s1_move) begin
      s2_valid <= 1'b1;
      word_idx <= 3'd0;
    end else if (s2_free) begin
      s2_valid <= 1'b0;
    end else if (out_xfer) begin
      word_idx <= word_idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) s2 <= s2_next;
  end

  always_comb begin
    serial_word = 16'd0;
    if (s2.kind == dtp_pkg::KIND_WORD) begin
      unique case (word_idx)
        3'd0:    serial_word = dtp_pkg::CTRL_WORD;
        3'd1:    serial_word = {dtp_pkg::FREQ_TAG, s2.lo};
        3'd2:    serial_word = {dtp_pkg::FREQ_TAG, s2.hi};
        3'd3:    serial_word = dtp_pkg::PHASE_WORD;
        default: serial_word = s2.wave_word;
      endcase
    end
  end

  assign result_kind = s2.kind;
  assign last_word   = (s2.kind == dtp_pkg::KIND_LINES) || (word_idx == dtp_pkg::WORD_LAST);
  assign data_level  = s2.data_lvl;
  assign clock_level = s2.clock_lvl;

  `ASSERT_IMPL(a_idle_burst, clk, rst, !burst_active,
               (bit_mask == dtp_pkg::MASK_RESET) && (half_count == 2'd0) && !data_line)
  `ASSERT_IMPL(a_tick_last, clk, rst, out_valid && (result_kind == dtp_pkg::KIND_LINES),
               last_word)
  `ASSERT_NEXT(a_words_continue, clk, rst, out_xfer && !last_word,
               out_valid && (result_kind == dtp_pkg::KIND_WORD))

endmodule
`default_nettype wire
